[hw/rtl/fsis_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the integer set unit.
package fsis_pkg;

   localparam int SET_SIZE  = 16;
   localparam int IDX_W     = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int ELEM_W    = 32;
   localparam int LARGEST_W = 31;
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

[hw/rtl/fsis_ctrl.sv]
// Controller state machine: accept an item, sequence the slot scan, commit and hand off the result.
module fsis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  fsis_pkg::status_type status,
   output fsis_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       commit_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign commit_ok = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd.load   = req_valid && req_ready;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = commit_ok;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_ok) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/fsis_datapath.sv]
// Datapath: slot table, scan counter, match/free/maximum trackers and result registers.
module fsis_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  fsis_pkg::cmd_type                 cmd,
   output fsis_pkg::status_type              status,
   input  logic [fsis_pkg::OP_W-1:0]         req_operation,
   input  logic signed [fsis_pkg::ELEM_W-1:0] req_element,
   output logic                              rsp_success,
   output logic [fsis_pkg::LARGEST_W-1:0]    rsp_largest_value,
   output logic                              rsp_largest_valid
);

   logic [fsis_pkg::ELEM_W-1:0]    slots_ff [fsis_pkg::SET_SIZE];
   logic [fsis_pkg::OP_W-1:0]      op_ff;
   logic [fsis_pkg::ELEM_W-1:0]    elem_ff;
   logic [fsis_pkg::IDX_W-1:0]     cnt_ff;
   logic [fsis_pkg::IDX_W-1:0]     cnt_in;
   logic                           found_ff;
   logic                           found_in;
   logic [fsis_pkg::IDX_W-1:0]     match_idx_ff;
   logic [fsis_pkg::IDX_W-1:0]     match_idx_in;
   logic                           free_ff;
   logic                           free_in;
   logic [fsis_pkg::IDX_W-1:0]     free_idx_ff;
   logic [fsis_pkg::IDX_W-1:0]     free_idx_in;
   logic [fsis_pkg::LARGEST_W-1:0] best_ff;
   logic [fsis_pkg::LARGEST_W-1:0] best_in;
   logic                           success_ff;
   logic                           success_in;
   logic [fsis_pkg::LARGEST_W-1:0] largest_ff;
   logic [fsis_pkg::LARGEST_W-1:0] largest_in;

   logic [fsis_pkg::ELEM_W-1:0]    cur;
   logic                           cur_match;
   logic                           cur_empty;
   logic                           cur_pos;
   logic                           cur_removed;
   logic                           elem_pos;
   logic                           wr_en;
   logic [fsis_pkg::IDX_W-1:0]     wr_idx;
   logic [fsis_pkg::ELEM_W-1:0]    wr_data;
   logic                           clear_all;

   assign cur         = slots_ff[cnt_ff];
   assign cur_match   = (cur == elem_ff);
   assign cur_empty   = (cur == '0);
   assign cur_pos     = !cur_empty && !cur[fsis_pkg::ELEM_W-1];
   assign cur_removed = (op_ff == fsis_pkg::OP_REMOVE) && cur_match && !found_ff;
   assign elem_pos    = (elem_ff != '0) && !elem_ff[fsis_pkg::ELEM_W-1];

   assign status.scan_last = (cnt_ff == fsis_pkg::IDX_W'(fsis_pkg::SET_SIZE - 1));

   // scan: track first match, first free slot and running maximum
   always_comb begin
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      if (cmd.load) begin
         cnt_in   = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
         best_in  = '0;
      end else if (cmd.scan) begin
         if (!status.scan_last) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (cur_match && !found_ff) begin
            found_in     = 1'b1;
            match_idx_in = cnt_ff;
         end
         if (cur_empty && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cnt_ff;
         end
         if (cur_pos && !cur_removed && (cur[fsis_pkg::LARGEST_W-1:0] > best_ff)) begin
            best_in = cur[fsis_pkg::LARGEST_W-1:0];
         end
      end
   end

   // commit: apply the operation and form the result
   always_comb begin
      wr_en      = 1'b0;
      wr_idx     = free_idx_ff;
      wr_data    = elem_ff;
      clear_all  = 1'b0;
      success_in = 1'b0;
      largest_in = best_ff;
      case (op_ff)
         fsis_pkg::OP_INSERT: begin
            success_in = !found_ff && free_ff;
            wr_en      = !found_ff && free_ff;
            if (!found_ff && free_ff && elem_pos &&
                (elem_ff[fsis_pkg::LARGEST_W-1:0] > best_ff)) begin
               largest_in = elem_ff[fsis_pkg::LARGEST_W-1:0];
            end
         end
         fsis_pkg::OP_QUERY: begin
            success_in = found_ff;
         end
         fsis_pkg::OP_REMOVE: begin
            success_in = found_ff;
            wr_en      = found_ff;
            wr_idx     = match_idx_ff;
            wr_data    = '0;
         end
         default: begin
            success_in = 1'b1;
            clear_all  = 1'b1;
            largest_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fsis_pkg::SET_SIZE; i++) begin
         if (reset || (cmd.commit && clear_all)) begin
            slots_ff[i] <= '0;
         end else if (cmd.commit && wr_en && (wr_idx == fsis_pkg::IDX_W'(i))) begin
            slots_ff[i] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         elem_ff <= req_element;
      end
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      if (cmd.commit) begin
         success_ff <= success_in;
         largest_ff <= largest_in;
      end
   end

   assign rsp_success       = success_ff;
   assign rsp_largest_value = largest_ff;
   assign rsp_largest_valid = (largest_ff != '0);

endmodule

[hw/rtl/fixed_slot_integer_set_unit.sv]
// Top level of the fixed-slot integer set unit.
// An accepted item is scanned across every slot, then committed, and its result is registered.
// A new item is accepted only after the previous one has committed; the scan reads one slot per cycle.
// The result register frees the input side while a result waits to be taken.
// Reset (synchronous, active high) empties every slot and drops any pending result.
module fixed_slot_integer_set_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fsis_pkg::OP_W-1:0]          req_operation,
   input  logic signed [fsis_pkg::ELEM_W-1:0] req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_success,
   output logic [fsis_pkg::LARGEST_W-1:0]     rsp_largest_value,
   output logic                               rsp_largest_valid
);

   fsis_pkg::cmd_type    cmd;
   fsis_pkg::status_type status;

   fsis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fsis_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_element       (req_element),
      .rsp_success       (rsp_success),
      .rsp_largest_value (rsp_largest_value),
      .rsp_largest_valid (rsp_largest_valid)
   );

endmodule

[hw/rtl/fsis_chk.sv]
// Port-level checker for the integer set unit and its bind to the top level.
module fsis_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_success,
   input logic [fsis_pkg::LARGEST_W-1:0]     rsp_largest_value,
   input logic                               rsp_largest_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success) &&
      $stable(rsp_largest_value) && $stable(rsp_largest_valid))
      else $error("result changed while stalled");

   a_largest_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_largest_valid == (rsp_largest_value != '0)))
      else $error("largest flag disagrees with largest value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken during a scan");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("unit not idle after reset");

endmodule

bind fixed_slot_integer_set_unit fsis_chk u_fsis_chk (.*);
